[src/vgc_pkg.sv]
// Shared types, constants and widths for the vertex grid clustering block.
`default_nettype none
package vgc_pkg;

    localparam int MAX_VERTICES = 65536;
    localparam int MAX_CLUSTERS = 65536;
    localparam int BUCKETS      = 16384;

    localparam int VID_W  = $clog2(MAX_VERTICES);
    localparam int CID_W  = $clog2(MAX_CLUSTERS);
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CCNT_W = $clog2(MAX_CLUSTERS + 1);

    localparam int POS_W   = 24;
    localparam int IDX_W   = 16;
    localparam int SCALE_W = 24;
    localparam int SUM_W   = 40;
    localparam int MEM_W   = 17;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    localparam int HASH_MUL_X = 17;
    localparam int HASH_MUL_Y = 101;

    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_TRI   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_NOT_LOADED = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_BKT,
        ST_ADD_CMP,
        ST_ADD_NEW,
        ST_TRI_A,
        ST_TRI_B,
        ST_TRI_C,
        ST_RD_REC,
        ST_RD_DIV,
        ST_OUT
    } state_t;

    // classified command handed from front to back
    typedef struct packed {
        action_t                   action;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic signed [POS_W-1:0]   cell_x;
        logic signed [POS_W-1:0]   cell_y;
        logic signed [POS_W-1:0]   cell_z;
        logic [BKT_W-1:0]          bucket;
        logic [IDX_W-1:0]          corner_a;
        logic [IDX_W-1:0]          corner_b;
        logic [IDX_W-1:0]          corner_c;
        logic [IDX_W-1:0]          cluster_pick;
    } cmd_t;

    typedef struct packed {
        logic signed [POS_W-1:0] cell_x;
        logic signed [POS_W-1:0] cell_y;
        logic signed [POS_W-1:0] cell_z;
        logic [SUM_W-1:0]        sum_x;
        logic [SUM_W-1:0]        sum_y;
        logic [SUM_W-1:0]        sum_z;
        logic [MEM_W-1:0]        count;
    } rec_t;

    typedef struct packed {
        logic             vld;
        logic [CID_W-1:0] id;
    } ptr_t;

    typedef struct packed {
        logic [IDX_W-1:0]  cluster_of_vertex;
        logic [IDX_W-1:0]  mapped_a;
        logic [IDX_W-1:0]  mapped_b;
        logic [IDX_W-1:0]  mapped_c;
        logic              keep_triangle;
        logic [POS_W-1:0]  avg_x;
        logic [POS_W-1:0]  avg_y;
        logic [POS_W-1:0]  avg_z;
        logic [MEM_W-1:0]  members;
        status_t           status;
    } res_t;

    typedef struct packed {
        logic init_done;
    } back_stat_t;

endpackage
`default_nettype wire

[src/vertex_grid_clustering.sv]
// Top level of the vertex grid clustering mesh decimator.
//
// Channel  Dir  Payload (lowest bit first)
// cfg      in   cfg_wdata: cell_scale, unsigned Q0.24
// s_       in   tdata: pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
//                      cluster_pick; tuser: action
// m_       out  tdata: cluster_of_vertex, mapped_a/b/c, keep_triangle, avg_x/y/z,
//                      members, pad; tuser: status
//
// The single read port of each store in the back end paces every item: an add reads
// the bucket head, compares one chain entry at a time and makes a new cluster when
// none matches; remap reads the three corners in turn; readout runs the 40-step
// three-lane divider (skipped when the count is zero); clear sweeps the bucket table.
// After reset a sweep of every bucket empties the table; s_tready stays low.
// Front and back are parted by a two-entry command queue; the output register
// lets the next transaction start while a result waits on m_tready.
`default_nettype none
module vertex_grid_clustering (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [23:0]  cfg_wdata,   // cell_scale
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,     // pos_x, pos_y, pos_z, corner_a, corner_b,
                                           // corner_c, cluster_pick
    input  wire logic [1:0]   s_tuser,     // action
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata,     // cluster_of_vertex, mapped_a, mapped_b,
                                           // mapped_c, keep_triangle, avg_x, avg_y,
                                           // avg_z, members, zero pad
    output logic [1:0]        m_tuser      // status
);
    vgc_pkg::cmd_t      push_data, pop_data;
    logic               push_valid, push_ready, pop_valid, pop_ready;
    vgc_pkg::back_stat_t bstat;
    vgc_pkg::res_t      res;

    // front: cell snap and bucket hash
    vgc_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .bstat(bstat), .push_valid(push_valid), .push_ready(push_ready),
        .push_data(push_data)
    );

    vgc_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push_valid(push_valid), .push_ready(push_ready),
        .push_data(push_data), .pop_valid(pop_valid), .pop_ready(pop_ready),
        .pop_data(pop_data)
    );

    // back: stores, chain walk, divider, result register
    vgc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(pop_valid), .q_pop(pop_ready),
        .q_head(pop_data), .bstat(bstat), .m_valid(m_tvalid), .m_ready(m_tready),
        .m_res(res)
    );

    assign m_tdata = {6'd0, res.members, res.avg_z, res.avg_y, res.avg_x,
                      res.keep_triangle, res.mapped_c, res.mapped_b, res.mapped_a,
                      res.cluster_of_vertex};
    assign m_tuser = res.status;
endmodule
`default_nettype wire

[src/vgc_ram.sv]
// Generic single write port, single registered read port RAM.
`default_nettype none
module vgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/vgc_queue.sv]
// Short command queue between front and back.
`default_nettype none
module vgc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire vgc_pkg::cmd_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output vgc_pkg::cmd_t      pop_data
);
    localparam int PW = (vgc_pkg::Q_DEPTH > 1) ? $clog2(vgc_pkg::Q_DEPTH) : 1;

    vgc_pkg::cmd_t   mem_reg [vgc_pkg::Q_DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign push_ready = cnt_reg != (PW+1)'(vgc_pkg::Q_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PW'(vgc_pkg::Q_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == PW'(vgc_pkg::Q_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

[src/vgc_front.sv]
// Front end: accepts items, snaps positions to grid cells and hashes the bucket.
`default_nettype none
module vgc_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [vgc_pkg::SCALE_W-1:0]    cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [135:0]                   s_tdata,
    input  wire logic [1:0]                     s_tuser,
    input  wire vgc_pkg::back_stat_t            bstat,
    output logic                                push_valid,
    input  wire logic                           push_ready,
    output vgc_pkg::cmd_t                       push_data
);
    logic [vgc_pkg::SCALE_W-1:0] scale_reg;
    logic                        s1_valid_reg, s1_valid_next;
    vgc_pkg::cmd_t               s1_reg, s1_next;
    logic                        take;

    logic signed [vgc_pkg::POS_W-1:0]     px, py, pz;
    logic signed [2*vgc_pkg::POS_W:0]     prod_x, prod_y, prod_z;
    logic signed [31:0]                   hsum;

    assign s_tready = bstat.init_done && (!s1_valid_reg || push_ready);
    assign take     = s_tvalid && s_tready;

    assign px = s_tdata[23:0];
    assign py = s_tdata[47:24];
    assign pz = s_tdata[71:48];

    // exact product, 24 fraction bits; the arithmetic slice is the floor
    assign prod_x = px * $signed({1'b0, scale_reg});
    assign prod_y = py * $signed({1'b0, scale_reg});
    assign prod_z = pz * $signed({1'b0, scale_reg});

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (push_ready) begin
            s1_valid_next = 1'b0;
        end
        if (take) begin
            s1_valid_next        = 1'b1;
            s1_next.action       = vgc_pkg::action_t'(s_tuser);
            s1_next.pos_x        = px;
            s1_next.pos_y        = py;
            s1_next.pos_z        = pz;
            s1_next.cell_x       = prod_x[47:24];
            s1_next.cell_y       = prod_y[47:24];
            s1_next.cell_z       = prod_z[47:24];
            s1_next.bucket       = '0;
            s1_next.corner_a     = s_tdata[87:72];
            s1_next.corner_b     = s_tdata[103:88];
            s1_next.corner_c     = s_tdata[119:104];
            s1_next.cluster_pick = s_tdata[135:120];
        end
    end

    // bucket = (17*cx + 101*cy + cz) masked to the table size
    assign hsum = 32'(s1_reg.cell_x) * vgc_pkg::HASH_MUL_X
                + 32'(s1_reg.cell_y) * vgc_pkg::HASH_MUL_Y
                + 32'(s1_reg.cell_z);

    always_comb begin
        push_data        = s1_reg;
        push_data.bucket = hsum[vgc_pkg::BKT_W-1:0];
    end
    assign push_valid = s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg    <= vgc_pkg::SCALE_RESET;
            s1_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                scale_reg <= cfg_wdata;
            end
            s1_valid_reg <= s1_valid_next;
        end
        s1_reg <= s1_next;
    end
endmodule
`default_nettype wire

[src/vgc_div.sv]
// Three-lane restoring divider, one quotient bit per cycle, signed truncation.
`default_nettype none
module vgc_div (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     start,
    input  wire logic [2:0][vgc_pkg::SUM_W-1:0]           dvd,
    input  wire logic [vgc_pkg::MEM_W-1:0]                dvs,
    output logic                                          done,
    output logic [2:0][vgc_pkg::POS_W-1:0]                quo
);
    localparam int SUM_W = vgc_pkg::SUM_W;
    localparam int MEM_W = vgc_pkg::MEM_W;
    localparam int CW    = $clog2(SUM_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [MEM_W-1:0]              dvs_reg, dvs_next;
    logic [2:0]                    neg_reg, neg_next;
    logic [2:0][MEM_W-1:0]         rem_reg, rem_next;
    logic [2:0][SUM_W-1:0]         q_reg, q_next;
    logic [MEM_W:0]                rem_sh;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        rem_sh    = '0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvs_next  = dvs;
            for (int l = 0; l < 3; l++) begin
                neg_next[l] = dvd[l][SUM_W-1];
                q_next[l]   = dvd[l][SUM_W-1] ? (~dvd[l] + 1'b1) : dvd[l];
                rem_next[l] = '0;
            end
        end else if (busy_reg) begin
            for (int l = 0; l < 3; l++) begin
                rem_sh = {rem_reg[l], q_reg[l][SUM_W-1]};
                if (rem_sh >= {1'b0, dvs_reg}) begin
                    rem_next[l] = MEM_W'(rem_sh - {1'b0, dvs_reg});
                    q_next[l]   = {q_reg[l][SUM_W-2:0], 1'b1};
                end else begin
                    rem_next[l] = rem_sh[MEM_W-1:0];
                    q_next[l]   = {q_reg[l][SUM_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            quo[l] = neg_reg[l] ? (~q_reg[l][vgc_pkg::POS_W-1:0] + 1'b1)
                                : q_reg[l][vgc_pkg::POS_W-1:0];
        end
    end
    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end
endmodule
`default_nettype wire

[src/vgc_back.sv]
// Back end: bucket sweep, hash chain walk, cluster store updates, remap, readout and output register.
`default_nettype none
module vgc_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire vgc_pkg::cmd_t        q_head,
    output vgc_pkg::back_stat_t       bstat,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output vgc_pkg::res_t             m_res
);
    localparam int CID_W  = vgc_pkg::CID_W;
    localparam int VID_W  = vgc_pkg::VID_W;
    localparam int BKT_W  = vgc_pkg::BKT_W;
    localparam int VCNT_W = vgc_pkg::VCNT_W;
    localparam int CCNT_W = vgc_pkg::CCNT_W;
    localparam int SUM_W  = vgc_pkg::SUM_W;
    localparam int IDX_W  = vgc_pkg::IDX_W;

    vgc_pkg::state_t  state_reg, state_next;
    vgc_pkg::cmd_t    cur_reg, cur_next;
    vgc_pkg::ptr_t    bkt_reg, bkt_next;
    vgc_pkg::res_t    res_reg, res_next, m_res_reg, m_res_next;
    logic             m_valid_reg, m_valid_next;
    logic [CID_W-1:0] walk_reg, walk_next;
    logic [CID_W-1:0] tri_a_reg, tri_a_next, tri_b_reg, tri_b_next;
    logic [VCNT_W-1:0] vload_reg, vload_next;
    logic [CCNT_W-1:0] cmade_reg, cmade_next;
    logic [BKT_W-1:0]  clr_reg, clr_next;
    logic              init_reg, init_next;

    // memory ports
    logic             bkt_we;
    logic [BKT_W-1:0] bkt_waddr, bkt_raddr;
    vgc_pkg::ptr_t    bkt_wdata, bkt_rdata;
    logic             rec_we, link_we;
    logic [CID_W-1:0] rec_waddr, rec_raddr;
    vgc_pkg::rec_t    rec_wdata, rec_rdata;
    vgc_pkg::ptr_t    link_rdata;
    logic             v2c_we;
    logic [VID_W-1:0] v2c_waddr, v2c_raddr;
    logic [CID_W-1:0] v2c_wdata, v2c_rdata;

    logic                               div_start, div_done;
    logic [2:0][SUM_W-1:0]              div_dvd;
    logic [2:0][vgc_pkg::POS_W-1:0]     div_quo;

    logic vfull, cfull, tri_bad, pick_bad, head_ok, link_ok, hit, clr_last, out_free;

    vgc_ram #(.WIDTH($bits(vgc_pkg::ptr_t)), .DEPTH(vgc_pkg::BUCKETS)) u_bkt (
        .aclk(aclk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
        .raddr(bkt_raddr), .rdata(bkt_rdata)
    );
    vgc_ram #(.WIDTH($bits(vgc_pkg::rec_t)), .DEPTH(vgc_pkg::MAX_CLUSTERS)) u_rec (
        .aclk(aclk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
        .raddr(rec_raddr), .rdata(rec_rdata)
    );
    vgc_ram #(.WIDTH($bits(vgc_pkg::ptr_t)), .DEPTH(vgc_pkg::MAX_CLUSTERS)) u_link (
        .aclk(aclk), .we(link_we), .waddr(rec_waddr), .wdata(bkt_reg),
        .raddr(rec_raddr), .rdata(link_rdata)
    );
    vgc_ram #(.WIDTH(CID_W), .DEPTH(vgc_pkg::MAX_VERTICES)) u_v2c (
        .aclk(aclk), .we(v2c_we), .waddr(v2c_waddr), .wdata(v2c_wdata),
        .raddr(v2c_raddr), .rdata(v2c_rdata)
    );
    vgc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dvd(div_dvd),
        .dvs(rec_rdata.count), .done(div_done), .quo(div_quo)
    );

    assign vfull    = vload_reg == VCNT_W'(vgc_pkg::MAX_VERTICES);
    assign cfull    = cmade_reg == CCNT_W'(vgc_pkg::MAX_CLUSTERS);
    assign tri_bad  = 32'(q_head.corner_a) >= 32'(vload_reg)
                   || 32'(q_head.corner_b) >= 32'(vload_reg)
                   || 32'(q_head.corner_c) >= 32'(vload_reg);
    assign pick_bad = 32'(q_head.cluster_pick) >= 32'(cmade_reg);
    assign head_ok  = bkt_rdata.vld && (32'(bkt_rdata.id) < 32'(cmade_reg));
    assign link_ok  = link_rdata.vld && (32'(link_rdata.id) < 32'(cmade_reg));
    assign hit      = rec_rdata.cell_x == cur_reg.cell_x
                   && rec_rdata.cell_y == cur_reg.cell_y
                   && rec_rdata.cell_z == cur_reg.cell_z;
    assign clr_last = clr_reg == BKT_W'(vgc_pkg::BUCKETS - 1);
    assign out_free = !m_valid_reg || m_ready;

    assign q_pop          = (state_reg == vgc_pkg::ST_IDLE) && q_valid;
    assign bstat.init_done = init_reg;
    assign m_valid        = m_valid_reg;
    assign m_res          = m_res_reg;

    always_comb begin
        div_dvd[0] = rec_rdata.sum_x;
        div_dvd[1] = rec_rdata.sum_y;
        div_dvd[2] = rec_rdata.sum_z;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vgc_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = init_reg ? vgc_pkg::ST_OUT : vgc_pkg::ST_IDLE;
                end
            end
            vgc_pkg::ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_head.action)
                        vgc_pkg::ACT_ADD:
                            state_next = vfull ? vgc_pkg::ST_OUT : vgc_pkg::ST_ADD_BKT;
                        vgc_pkg::ACT_TRI:
                            state_next = tri_bad ? vgc_pkg::ST_OUT : vgc_pkg::ST_TRI_A;
                        vgc_pkg::ACT_READ:
                            state_next = pick_bad ? vgc_pkg::ST_OUT : vgc_pkg::ST_RD_REC;
                        default:
                            state_next = vgc_pkg::ST_CLEAR;
                    endcase
                end
            end
            vgc_pkg::ST_ADD_BKT:
                state_next = head_ok ? vgc_pkg::ST_ADD_CMP : vgc_pkg::ST_ADD_NEW;
            vgc_pkg::ST_ADD_CMP: begin
                if (hit) begin
                    state_next = vgc_pkg::ST_OUT;
                end else if (!link_ok) begin
                    state_next = vgc_pkg::ST_ADD_NEW;
                end
            end
            vgc_pkg::ST_ADD_NEW: state_next = vgc_pkg::ST_OUT;
            vgc_pkg::ST_TRI_A:   state_next = vgc_pkg::ST_TRI_B;
            vgc_pkg::ST_TRI_B:   state_next = vgc_pkg::ST_TRI_C;
            vgc_pkg::ST_TRI_C:   state_next = vgc_pkg::ST_OUT;
            vgc_pkg::ST_RD_REC:
                state_next = (rec_rdata.count == '0) ? vgc_pkg::ST_OUT : vgc_pkg::ST_RD_DIV;
            vgc_pkg::ST_RD_DIV: begin
                if (div_done) begin
                    state_next = vgc_pkg::ST_OUT;
                end
            end
            vgc_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = vgc_pkg::ST_IDLE;
                end
            end
            default: state_next = vgc_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        cur_next     = cur_reg;
        bkt_next     = bkt_reg;
        res_next     = res_reg;
        m_res_next   = m_res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        walk_next    = walk_reg;
        tri_a_next   = tri_a_reg;
        tri_b_next   = tri_b_reg;
        vload_next   = vload_reg;
        cmade_next   = cmade_reg;
        clr_next     = clr_reg;
        init_next    = init_reg;
        div_start    = 1'b0;

        bkt_we    = 1'b0;
        bkt_waddr = cur_reg.bucket;
        bkt_wdata = '{vld: 1'b1, id: cmade_reg[CID_W-1:0]};
        bkt_raddr = q_head.bucket;
        rec_we    = 1'b0;
        link_we   = 1'b0;
        rec_waddr = cmade_reg[CID_W-1:0];
        rec_wdata = '{cell_x: cur_reg.cell_x, cell_y: cur_reg.cell_y,
                      cell_z: cur_reg.cell_z,
                      sum_x: SUM_W'(cur_reg.pos_x), sum_y: SUM_W'(cur_reg.pos_y),
                      sum_z: SUM_W'(cur_reg.pos_z), count: vgc_pkg::MEM_W'(1)};
        rec_raddr = walk_reg;
        v2c_we    = 1'b0;
        v2c_waddr = vload_reg[VID_W-1:0];
        v2c_wdata = cmade_reg[CID_W-1:0];
        v2c_raddr = VID_W'(q_head.corner_a);

        unique case (state_reg)
            vgc_pkg::ST_CLEAR: begin
                bkt_we    = 1'b1;
                bkt_waddr = clr_reg;
                bkt_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_last) begin
                    init_next = 1'b1;
                end
            end
            vgc_pkg::ST_IDLE: begin
                rec_raddr = CID_W'(q_head.cluster_pick);
                if (q_valid) begin
                    cur_next = q_head;
                    res_next = '0;
                    unique case (q_head.action)
                        vgc_pkg::ACT_ADD: begin
                            if (vfull) begin
                                res_next.status = vgc_pkg::STAT_FULL;
                            end
                        end
                        vgc_pkg::ACT_TRI: begin
                            if (tri_bad) begin
                                res_next.status = vgc_pkg::STAT_NOT_LOADED;
                            end
                        end
                        vgc_pkg::ACT_READ: begin
                            if (pick_bad) begin
                                res_next.status = vgc_pkg::STAT_NOT_LOADED;
                            end
                        end
                        default: begin
                            clr_next   = '0;
                            vload_next = '0;
                            cmade_next = '0;
                        end
                    endcase
                end
            end
            vgc_pkg::ST_ADD_BKT: begin
                bkt_next  = bkt_rdata;
                rec_raddr = bkt_rdata.id;
                walk_next = bkt_rdata.id;
            end
            vgc_pkg::ST_ADD_CMP: begin
                if (hit) begin
                    rec_we          = 1'b1;
                    rec_waddr       = walk_reg;
                    rec_wdata       = rec_rdata;
                    rec_wdata.sum_x = rec_rdata.sum_x + SUM_W'(cur_reg.pos_x);
                    rec_wdata.sum_y = rec_rdata.sum_y + SUM_W'(cur_reg.pos_y);
                    rec_wdata.sum_z = rec_rdata.sum_z + SUM_W'(cur_reg.pos_z);
                    rec_wdata.count = rec_rdata.count + 1'b1;
                    v2c_we          = 1'b1;
                    v2c_wdata       = walk_reg;
                    vload_next      = vload_reg + 1'b1;
                    res_next.cluster_of_vertex = IDX_W'(walk_reg);
                end else begin
                    rec_raddr = link_rdata.id;
                    walk_next = link_rdata.id;
                end
            end
            vgc_pkg::ST_ADD_NEW: begin
                if (cfull) begin
                    res_next.status = vgc_pkg::STAT_FULL;
                end else begin
                    rec_we     = 1'b1;
                    link_we    = 1'b1;
                    bkt_we     = 1'b1;
                    v2c_we     = 1'b1;
                    vload_next = vload_reg + 1'b1;
                    cmade_next = cmade_reg + 1'b1;
                    res_next.cluster_of_vertex = IDX_W'(cmade_reg[CID_W-1:0]);
                end
            end
            vgc_pkg::ST_TRI_A: begin
                tri_a_next = v2c_rdata;
                v2c_raddr  = VID_W'(cur_reg.corner_b);
            end
            vgc_pkg::ST_TRI_B: begin
                tri_b_next = v2c_rdata;
                v2c_raddr  = VID_W'(cur_reg.corner_c);
            end
            vgc_pkg::ST_TRI_C: begin
                res_next.mapped_a      = IDX_W'(tri_a_reg);
                res_next.mapped_b      = IDX_W'(tri_b_reg);
                res_next.mapped_c      = IDX_W'(v2c_rdata);
                res_next.keep_triangle = (tri_a_reg != tri_b_reg) && (tri_b_reg != v2c_rdata)
                                      && (v2c_rdata != tri_a_reg);
            end
            vgc_pkg::ST_RD_REC: begin
                res_next.members = rec_rdata.count;
                div_start        = rec_rdata.count != '0;
            end
            vgc_pkg::ST_RD_DIV: begin
                if (div_done) begin
                    res_next.avg_x = div_quo[0];
                    res_next.avg_y = div_quo[1];
                    res_next.avg_z = div_quo[2];
                end
            end
            vgc_pkg::ST_OUT: begin
                if (out_free) begin
                    m_res_next   = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= vgc_pkg::ST_CLEAR;
            m_valid_reg <= 1'b0;
            vload_reg   <= '0;
            cmade_reg   <= '0;
            clr_reg     <= '0;
            init_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            vload_reg   <= vload_next;
            cmade_reg   <= cmade_next;
            clr_reg     <= clr_next;
            init_reg    <= init_next;
        end
        cur_reg   <= cur_next;
        bkt_reg   <= bkt_next;
        res_reg   <= res_next;
        m_res_reg <= m_res_next;
        walk_reg  <= walk_next;
        tri_a_reg <= tri_a_next;
        tri_b_reg <= tri_b_next;
    end

`ifndef NO_ASSERTIONS
    a_cmade_le_vload: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cmade_reg) <= 32'(vload_reg))
        else $error("more clusters than recorded vertices");

    a_vload_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(vload_reg) <= vgc_pkg::MAX_VERTICES)
        else $error("vertex count beyond store");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == vgc_pkg::ST_RD_DIV)
        else $error("divider finished outside readout");

    a_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == vgc_pkg::ST_CLEAR |-> !q_pop && !rec_we && !v2c_we)
        else $error("store activity during bucket sweep");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vgc_pkg::ST_OUT && out_free) |=> m_valid_reg)
        else $error("result not presented");
`endif
endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the vertex grid clustering block.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 60;    // wait after the last result; covers a readout with margin

    // one input transaction
    typedef struct {
        vgc_pkg::action_t                 act;
        logic signed [vgc_pkg::POS_W-1:0] px, py, pz;
        logic [vgc_pkg::IDX_W-1:0]        ca, cb, cc, pick;
    } vtx_cmd_t;

    // one result transaction
    typedef struct packed {
        logic [vgc_pkg::IDX_W-1:0] cov, ma, mb, mc;
        logic                      keep;
        logic [vgc_pkg::POS_W-1:0] ax, ay, az;
        logic [vgc_pkg::MEM_W-1:0] members;
        vgc_pkg::status_t          status;
    } vtx_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [23:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic [1:0]   m_tuser;

    always #6 aclk = ~aclk;

    vertex_grid_clustering u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // pending commands and expected results
    vtx_cmd_t cmd_q[$];
    vtx_res_t expect_q[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       n_errors = 0;
    int       n_cycles = 0;
    logic     s_took = 1'b0;

    // shadow of the clustering tables
    logic [vgc_pkg::SCALE_W-1:0] sh_scale = vgc_pkg::SCALE_RESET;
    int unsigned                 sh_loaded = 0;
    int unsigned                 sh_made = 0;
    int                          cell_to_id[bit [95:0]];
    logic [vgc_pkg::SUM_W-1:0]   sh_sx[vgc_pkg::MAX_CLUSTERS];
    logic [vgc_pkg::SUM_W-1:0]   sh_sy[vgc_pkg::MAX_CLUSTERS];
    logic [vgc_pkg::SUM_W-1:0]   sh_sz[vgc_pkg::MAX_CLUSTERS];
    logic [vgc_pkg::MEM_W-1:0]   sh_cnt[vgc_pkg::MAX_CLUSTERS];
    logic [vgc_pkg::IDX_W-1:0]   sh_v2c[vgc_pkg::MAX_VERTICES];

    // generator-side guess of how many vertices are loaded
    int gen_loaded = 0;

    // floor(pos * scale / 2^24); arithmetic shift rounds toward minus infinity
    function automatic logic [31:0] grid_cell(logic signed [vgc_pkg::POS_W-1:0] p);
        longint prod;
        prod = longint'(p) * longint'({1'b0, sh_scale});
        return 32'(prod >>> 24);
    endfunction

    function automatic logic [vgc_pkg::POS_W-1:0] mean_of(logic [vgc_pkg::SUM_W-1:0] s,
                                                          logic [vgc_pkg::MEM_W-1:0] n);
        longint q;
        q = longint'($signed(s)) / longint'({1'b0, n});
        return q[vgc_pkg::POS_W-1:0];
    endfunction

    function automatic vtx_res_t cluster_predict(vtx_cmd_t c);
        vtx_res_t   r;
        bit [95:0]  key;
        int         id;
        r = '{default: '0, status: vgc_pkg::STAT_OK};
        case (c.act)
            vgc_pkg::ACT_ADD: begin
                if (sh_loaded >= vgc_pkg::MAX_VERTICES) begin
                    r.status = vgc_pkg::STAT_FULL;
                end else begin
                    key = {grid_cell(c.px), grid_cell(c.py), grid_cell(c.pz)};
                    if (cell_to_id.exists(key)) begin
                        id = cell_to_id[key];
                        sh_sx[id] = sh_sx[id] + vgc_pkg::SUM_W'(c.px);
                        sh_sy[id] = sh_sy[id] + vgc_pkg::SUM_W'(c.py);
                        sh_sz[id] = sh_sz[id] + vgc_pkg::SUM_W'(c.pz);
                        sh_cnt[id] = sh_cnt[id] + 1'b1;
                    end else if (sh_made >= vgc_pkg::MAX_CLUSTERS) begin
                        r.status = vgc_pkg::STAT_FULL;
                        return r;
                    end else begin
                        id = sh_made++;
                        cell_to_id[key] = id;
                        sh_sx[id] = vgc_pkg::SUM_W'(c.px);
                        sh_sy[id] = vgc_pkg::SUM_W'(c.py);
                        sh_sz[id] = vgc_pkg::SUM_W'(c.pz);
                        sh_cnt[id] = vgc_pkg::MEM_W'(1);
                    end
                    sh_v2c[sh_loaded++] = vgc_pkg::IDX_W'(id);
                    r.cov = vgc_pkg::IDX_W'(id);
                end
            end
            vgc_pkg::ACT_TRI: begin
                if (c.ca >= sh_loaded || c.cb >= sh_loaded || c.cc >= sh_loaded) begin
                    r.status = vgc_pkg::STAT_NOT_LOADED;
                end else begin
                    r.ma = sh_v2c[c.ca];
                    r.mb = sh_v2c[c.cb];
                    r.mc = sh_v2c[c.cc];
                    r.keep = (r.ma != r.mb) && (r.mb != r.mc) && (r.mc != r.ma);
                end
            end
            vgc_pkg::ACT_READ: begin
                if (c.pick >= sh_made) begin
                    r.status = vgc_pkg::STAT_NOT_LOADED;
                end else begin
                    r.members = sh_cnt[c.pick];
                    if (r.members != 0) begin
                        r.ax = mean_of(sh_sx[c.pick], r.members);
                        r.ay = mean_of(sh_sy[c.pick], r.members);
                        r.az = mean_of(sh_sz[c.pick], r.members);
                    end
                end
            end
            default: begin
                cell_to_id.delete();
                sh_loaded = 0;
                sh_made = 0;
            end
        endcase
        return r;
    endfunction

    // driver: a new transaction goes out once the previous one was taken
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_took)) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                vtx_cmd_t c;
                c = cmd_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= c.act;
                s_tdata  <= {c.pick, c.cc, c.cb, c.ca, c.pz, c.py, c.px};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // input side: register writes and accepted transactions feed the shadow
    always @(posedge aclk) begin
        vtx_cmd_t c;
        s_took <= s_tvalid && s_tready;
        if (aresetn && cfg_we)
            sh_scale = cfg_wdata;
        if (aresetn && s_tvalid && s_tready) begin
            c.act  = vgc_pkg::action_t'(s_tuser);
            c.px   = s_tdata[23:0];
            c.py   = s_tdata[47:24];
            c.pz   = s_tdata[71:48];
            c.ca   = s_tdata[87:72];
            c.cb   = s_tdata[103:88];
            c.cc   = s_tdata[119:104];
            c.pick = s_tdata[135:120];
            expect_q.insert(expect_q.size(), cluster_predict(c));
        end
    end

    // output side: compare with the oldest expectation
    always @(posedge aclk) begin
        vtx_res_t e, a;
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            a.cov     = m_tdata[15:0];
            a.ma      = m_tdata[31:16];
            a.mb      = m_tdata[47:32];
            a.mc      = m_tdata[63:48];
            a.keep    = m_tdata[64];
            a.ax      = m_tdata[88:65];
            a.ay      = m_tdata[112:89];
            a.az      = m_tdata[136:113];
            a.members = m_tdata[153:137];
            a.status  = vgc_pkg::status_t'(m_tuser);
            if (expect_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result transaction at cycle %0d", n_cycles);
            end else begin
                e = expect_q.pop_front();
                if (a != e) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("mismatch: exp cov %0d tri %0d %0d %0d k%0b avg %h %h %h m%0d st%0d",
                                 e.cov, e.ma, e.mb, e.mc, e.keep, e.ax, e.ay, e.az,
                                 e.members, e.status);
                        $display("          got cov %0d tri %0d %0d %0d k%0b avg %h %h %h m%0d st%0d",
                                 a.cov, a.ma, a.mb, a.mc, a.keep, a.ax, a.ay, a.az,
                                 a.members, a.status);
                    end
                end
            end
        end
    end

    task automatic push_cmd(vgc_pkg::action_t act, int px, int py, int pz,
                            int ca, int cb, int cc, int pick);
        vtx_cmd_t c;
        c.act = act;
        c.px = vgc_pkg::POS_W'(px);
        c.py = vgc_pkg::POS_W'(py);
        c.pz = vgc_pkg::POS_W'(pz);
        c.ca = vgc_pkg::IDX_W'(ca);
        c.cb = vgc_pkg::IDX_W'(cb);
        c.cc = vgc_pkg::IDX_W'(cc);
        c.pick = vgc_pkg::IDX_W'(pick);
        cmd_q.insert(cmd_q.size(), c);
        if (act == vgc_pkg::ACT_ADD)
            gen_loaded++;
        else if (act == vgc_pkg::ACT_CLEAR)
            gen_loaded = 0;
    endtask

    // everything sent, everything back, then let the back end settle
    task automatic drain;
        while (cmd_q.size() != 0 || s_tvalid || expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_scale(logic [23:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int rand_pos();
        int k;
        k = $urandom_range(9);
        if (k < 6)
            return $urandom_range(4095) - 2048;
        else if (k < 8)
            return $urandom;
        else
            return (k == 8) ? 32'h7FFFFF : 32'h800000;
    endfunction

    function automatic int rand_index(int hi);
        if ($urandom_range(19) == 0)
            return $urandom_range(65535);
        return $urandom_range(hi + 1);
    endfunction

    task automatic push_random;
        int k;
        vgc_pkg::action_t act;
        k = $urandom_range(999);
        if (k < 5)
            act = vgc_pkg::ACT_CLEAR;
        else if (k < 500)
            act = vgc_pkg::ACT_ADD;
        else if (k < 780)
            act = vgc_pkg::ACT_TRI;
        else
            act = vgc_pkg::ACT_READ;
        push_cmd(act, rand_pos(), rand_pos(), rand_pos(),
                 rand_index(gen_loaded), rand_index(gen_loaded),
                 rand_index(gen_loaded), rand_index(gen_loaded));
    endtask

    task automatic random_phase(int n, int send_pct, int recv_pct, logic [23:0] scale);
        drain();
        write_scale(scale);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) push_random();
        drain();
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, floor of negatives, every action, each special case
        write_scale(24'd65536);
        push_cmd(vgc_pkg::ACT_TRI, 0, 0, 0, 0, 0, 0, 0);        // nothing loaded yet
        push_cmd(vgc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0);       // no cluster made
        push_cmd(vgc_pkg::ACT_ADD, 32'h7FFFFF, 32'h800000, -1, 0, 0, 0, 0);
        push_cmd(vgc_pkg::ACT_ADD, 32'h7FFFF0, 32'h800010, -200, 0, 0, 0, 0); // same cell
        push_cmd(vgc_pkg::ACT_ADD, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(vgc_pkg::ACT_ADD, 1, -1, 255, 0, 0, 0, 0);     // x same, y below zero
        push_cmd(vgc_pkg::ACT_ADD, 256, 256, 256, 0, 0, 0, 0);
        push_cmd(vgc_pkg::ACT_TRI, 0, 0, 0, 0, 1, 2, 0);        // collapsed
        push_cmd(vgc_pkg::ACT_TRI, 0, 0, 0, 0, 2, 4, 0);        // kept
        push_cmd(vgc_pkg::ACT_TRI, 0, 0, 0, 4, 4, 4, 0);
        push_cmd(vgc_pkg::ACT_TRI, 0, 0, 0, 0, 1, 5, 0);        // one corner past end
        push_cmd(vgc_pkg::ACT_TRI, 0, 0, 0, 65535, 65535, 65535, 65535);
        push_cmd(vgc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(vgc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 3);
        push_cmd(vgc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 65535);
        push_cmd(vgc_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(vgc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0);       // gone after clear
        push_cmd(vgc_pkg::ACT_TRI, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // zero scale puts every vertex in one cell: one long merge, signed averages
        write_scale(24'd0);
        repeat (40)
            push_cmd(vgc_pkg::ACT_ADD, rand_pos(), rand_pos(), rand_pos(), 0, 0, 0, 0);
        push_cmd(vgc_pkg::ACT_TRI, 0, 0, 0, 0, 39, 20, 0);      // all one cluster
        push_cmd(vgc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0);       // full count
        push_cmd(vgc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 1);       // only one cluster
        push_cmd(vgc_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        drain();

        // random phases; the sender waits for an empty pipe between each
        random_phase(330, 0, 0, 24'd65536);
        random_phase(330, 72, 0, 24'hFFFFFF);
        random_phase(330, 0, 72, 24'd4096);
        random_phase(260, 19, 19, 24'($urandom));

        if (n_errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
src/vgc_pkg.sv
src/vgc_ram.sv
src/vgc_queue.sv
src/vgc_front.sv
src/vgc_div.sv
src/vgc_back.sv
src/vertex_grid_clustering.sv
tb/tb.sv
